// ----- hw/rtl/igtp_pkg.sv -----
// ----------------------------------------------------------------------------
// igtp_pkg
// Shared codes, character constants and the result type of the integer grid
// text parser.
// ----------------------------------------------------------------------------
package igtp_pkg;

  localparam logic [1:0] CMD_CHAR = 2'd0;
  localparam logic [1:0] CMD_EOL  = 2'd1;
  localparam logic [1:0] CMD_EOF  = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_SYMBOL = 3'd1;
  localparam logic [2:0] ERR_TOO_BIG    = 3'd2;
  localparam logic [2:0] ERR_EMPTY_ROW  = 3'd3;
  localparam logic [2:0] ERR_LEN_DIFFER = 3'd4;
  localparam logic [2:0] ERR_EMPTY_MAP  = 3'd5;
  localparam logic [2:0] ERR_TOO_LARGE  = 3'd6;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SIGN   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  localparam logic [34:0] INT_TOP     = 35'd2147483647;
  localparam logic [3:0]  DIGIT_LIMIT = 4'd11;

  typedef struct packed {
    logic signed [31:0] value;
    logic [10:0]        row;
    logic [10:0]        col;
    logic               has_value;
    logic               row_end;
    logic               map_done;
    logic [2:0]         error;
  } result_t;

endpackage

// ----- hw/rtl/integer_grid_text_parser.sv -----
// ----------------------------------------------------------------------------
// integer_grid_text_parser
// Streaming parser for a text grid of space-separated signed decimal numbers.
//
// The input channel (in_valid, in_stall, cmd, ch) carries one request per
// character, end of line or end of file. The output channel (out_valid,
// out_stall and the result fields) carries each completed number with its
// row and column, row closures, the grid size at end of file, and errors.
// A request passes through an input register and then through the
// combinational parser update into the result register. One request is
// taken every cycle while no result is held under out_stall.
// While a result waits under out_stall, the request in the input register
// holds and in_stall rises, so nothing is lost or repeated.
// Reset clears all parser state and the valid flags of both registers at
// once. An error is reported once and then every request is absorbed without
// a result until reset. A good end of file returns the parser to its reset
// state.
// ----------------------------------------------------------------------------
module integer_grid_text_parser #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic [7:0]         ch,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value,
  output logic [10:0]        row,
  output logic [10:0]        col,
  output logic               has_value,
  output logic               row_end,
  output logic               map_done,
  output logic [2:0]         error
);
  import igtp_pkg::*;

  logic       req_valid;
  logic [1:0] req_cmd;
  logic [7:0] req_ch;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  assign step     = req_valid && !(out_valid && out_stall);
  assign in_stall = req_valid && out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_cmd <= cmd;
      req_ch  <= ch;
    end
  end

  igtp_parser #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .cmd      (req_cmd),
    .ch       (req_ch),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res <= res;
    end
  end

  assign value     = out_res.value;
  assign row       = out_res.row;
  assign col       = out_res.col;
  assign has_value = out_res.has_value;
  assign row_end   = out_res.row_end;
  assign map_done  = out_res.map_done;
  assign error     = out_res.error;

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && error != ERR_NONE |-> !has_value && !row_end && !map_done && value == 0)
    else $error("error result carries other fields");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && req_valid)
    else $error("input stalled without a blocked result");

  a_value_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && has_value |-> error == ERR_NONE && value != 32'sh80000000)
    else $error("number result out of range or flagged as error");

endmodule

// ----- hw/rtl/igtp_parser.sv -----
// ----------------------------------------------------------------------------
// igtp_parser
// Parser state and the combinational update that folds one request into it,
// producing at most one result.
// ----------------------------------------------------------------------------
module igtp_parser #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic [1:0]       cmd,
  input  logic [7:0]       ch,
  output logic             res_valid,
  output igtp_pkg::result_t res
);
  import igtp_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);

  logic [1:0]    phase, phase_next;
  logic          negative, negative_next;
  logic [30:0]   magnitude, magnitude_next;
  logic [3:0]    digit_count, digit_count_next;
  logic [CW-1:0] col_count, col_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic [CW-1:0] row_width, row_width_next;
  logic          failed, failed_next;
  logic          line_open, line_open_next;

  logic [34:0]   mag_acc;
  logic [3:0]    digit;
  logic          is_digit;
  logic          close_line;
  logic [2:0]    err;
  logic [CW-1:0] count;
  logic [RW+10:0] row_wide;
  logic [CW+10:0] col_wide;
  logic [CW+10:0] count_wide;
  logic [RW+10:0] row_next_wide;
  logic [CW+10:0] width_next_wide;
  result_t        res_c;
  logic           rv;

  assign digit    = 4'(ch - CH_ZERO);
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);

  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    magnitude_next   = magnitude;
    digit_count_next = digit_count;
    col_count_next   = col_count;
    row_count_next   = row_count;
    row_width_next   = row_width;
    failed_next      = failed;
    line_open_next   = line_open;
    mag_acc          = '0;
    close_line       = 1'b0;
    err              = ERR_NONE;
    count            = col_count;
    res_c            = '0;
    rv               = 1'b0;
    row_wide         = {11'd0, row_count};
    col_wide         = {11'd0, col_count};
    count_wide       = '0;
    row_next_wide    = '0;
    width_next_wide  = '0;

    if (!failed && cmd != CMD_NONE) begin
      if (cmd == CMD_CHAR) begin
        line_open_next = 1'b1;
        if (is_digit) begin
          if (phase == PH_DIGITS) begin
            mag_acc = ({4'd0, magnitude} << 3) + ({4'd0, magnitude} << 1) + 35'(digit);
            if (digit_count < DIGIT_LIMIT) begin
              digit_count_next = digit_count + 4'd1;
            end
          end else begin
            negative_next    = (phase == PH_SIGN);
            mag_acc          = 35'(digit);
            digit_count_next = 4'd1;
            phase_next       = PH_DIGITS;
          end
          magnitude_next = mag_acc[30:0];
          if (digit_count_next >= DIGIT_LIMIT || mag_acc > INT_TOP) begin
            err = ERR_TOO_BIG;
          end
        end else if (ch == CH_MINUS) begin
          if (phase != PH_IDLE) begin
            err = ERR_BAD_SYMBOL;
          end else begin
            phase_next = PH_SIGN;
          end
        end else if (ch == CH_SPACE) begin
          if (phase == PH_SIGN) begin
            err = ERR_BAD_SYMBOL;
          end else if (phase == PH_DIGITS) begin
            if (32'(row_count) >= 32'(MAX_ROWS) || 32'(col_count) >= 32'(MAX_COLS)) begin
              err = ERR_TOO_LARGE;
            end else begin
              res_c.value     = negative ? -$signed({1'b0, magnitude})
                                         : $signed({1'b0, magnitude});
              res_c.row       = row_wide[10:0];
              res_c.col       = col_wide[10:0];
              res_c.has_value = 1'b1;
              col_count_next  = col_count + 1'b1;
              phase_next       = PH_IDLE;
              negative_next    = 1'b0;
              magnitude_next   = '0;
              digit_count_next = '0;
              rv               = 1'b1;
            end
          end
        end else begin
          err = ERR_BAD_SYMBOL;
        end
      end else begin
        rv         = 1'b1;
        close_line = (cmd == CMD_EOL) || line_open;
        if (close_line) begin
          if (phase == PH_SIGN) begin
            err = ERR_BAD_SYMBOL;
          end else begin
            if (phase == PH_DIGITS) begin
              if (32'(row_count) >= 32'(MAX_ROWS) || 32'(col_count) >= 32'(MAX_COLS)) begin
                err = ERR_TOO_LARGE;
              end else begin
                res_c.value     = negative ? -$signed({1'b0, magnitude})
                                           : $signed({1'b0, magnitude});
                res_c.row       = row_wide[10:0];
                res_c.col       = col_wide[10:0];
                res_c.has_value = 1'b1;
                count           = col_count + 1'b1;
              end
            end
            if (err == ERR_NONE) begin
              count_wide = {11'd0, count};
              if (count == '0) begin
                err = ERR_EMPTY_ROW;
              end else if (row_width != '0 && count != row_width) begin
                err = ERR_LEN_DIFFER;
              end else begin
                row_width_next = count;
                if (!res_c.has_value) begin
                  res_c.row = row_wide[10:0];
                  res_c.col = count_wide[10:0];
                end
                row_count_next   = row_count + 1'b1;
                col_count_next   = '0;
                line_open_next   = 1'b0;
                phase_next       = PH_IDLE;
                negative_next    = 1'b0;
                magnitude_next   = '0;
                digit_count_next = '0;
                res_c.row_end    = 1'b1;
              end
            end
          end
        end
        if (cmd == CMD_EOF && err == ERR_NONE) begin
          row_next_wide   = {11'd0, row_count_next};
          width_next_wide = {11'd0, row_width_next};
          if (row_count_next == '0) begin
            err = ERR_EMPTY_MAP;
          end else begin
            res_c.map_done = 1'b1;
            if (!res_c.has_value) begin
              res_c.row = row_next_wide[10:0];
              res_c.col = width_next_wide[10:0];
            end
            phase_next       = PH_IDLE;
            negative_next    = 1'b0;
            magnitude_next   = '0;
            digit_count_next = '0;
            col_count_next   = '0;
            row_count_next   = '0;
            row_width_next   = '0;
            line_open_next   = 1'b0;
          end
        end
      end

      if (err != ERR_NONE) begin
        res_c       = '0;
        res_c.error = err;
        rv          = 1'b1;
        failed_next = 1'b1;
      end
    end
  end

  assign res_valid = rv;
  assign res       = res_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      negative    <= 1'b0;
      magnitude   <= '0;
      digit_count <= '0;
      col_count   <= '0;
      row_count   <= '0;
      row_width   <= '0;
      failed      <= 1'b0;
      line_open   <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      negative    <= negative_next;
      magnitude   <= magnitude_next;
      digit_count <= digit_count_next;
      col_count   <= col_count_next;
      row_count   <= row_count_next;
      row_width   <= row_width_next;
      failed      <= failed_next;
      line_open   <= line_open_next;
    end
  end

endmodule
